>>> src/bed_genotype_transposed_matvec_unit_assert.svh
// Assertion macros for the genotype projection unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BED_GENOTYPE_TRANSPOSED_MATVEC_UNIT_ASSERT_SVH
`define BED_GENOTYPE_TRANSPOSED_MATVEC_UNIT_ASSERT_SVH

// implication checked at every edge outside reset
`define BGT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BGT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/bgtmv_pkg.sv
// Shared types and constants for the genotype projection unit.
// No dependencies.
package bgtmv_pkg;
    localparam int LANES = 4;
    localparam int MAX_SAMPLES = 4096;
    localparam int SUM_WIDTH   = 48;
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_GENO   = 1'b1;
    localparam logic [1:0] CODE_HOM2 = 2'd0;
    localparam logic [1:0] CODE_MISS = 2'd1;
    localparam logic [1:0] CODE_HET  = 2'd2;
    localparam logic [1:0] CODE_HOM0 = 2'd3;
    localparam int TERM_W = 35; // 19-bit (g-2m) times 16-bit weight
endpackage

>>> src/bed_genotype_transposed_matvec_unit.sv
// Top level of the genotype projection unit: weight RAM, four lanes,
// saturating merge/accumulate, serial divider. Depends on bgtmv_pkg and submodules.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid/s_ready    | opcode, weight_index, weight_value, geno_byte,...
//  m_      | out | m_valid/m_ready    | projection, saturated
//  cfg     | in  | cfg_valid/cfg_ready| cfg_data (sample_count)
//
// One transaction in flight at a time. A weight load is written to the RAM when
// accepted; a genotype byte passes through RAM read, lane multiply and merge;
// a last byte then adds the one-bit-per-cycle divider and result handoff. Reset
// is synchronous and active low; the weight RAM is not cleared. While a result
// waits on m_ready, s_ready stays low.
`include "bed_genotype_transposed_matvec_unit_assert.svh"
module bed_genotype_transposed_matvec_unit import bgtmv_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [11:0]        s_weight_index,
    input  logic signed [15:0] s_weight_value,
    input  logic [7:0]         s_geno_byte,
    input  logic [15:0]        s_mean_freq,
    input  logic [15:0]        s_scale,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_projection,
    output logic               m_saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int PW = AW + 3;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_ACC, S_DIV, S_WAIT} state_t;
    state_t state_reg;

    logic [12:0] count_reg;
    logic [PW-1:0] pos_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic [7:0] byte_reg;
    logic [15:0] mean_reg, scale_reg;
    logic last_reg;
    logic [LANES-1:0] act;
    logic [PW-1:0] limit;
    logic signed [15:0] w [LANES];
    logic signed [TERM_W-1:0] term [LANES];
    logic signed [SUM_WIDTH+2:0] add;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic div_start, div_busy, div_done, div_sat;
    logic signed [31:0] div_q;
    logic s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready = state_reg == S_IDLE && !(m_valid && !m_ready);
    assign s_fire = s_valid && s_ready;
    assign limit = ({3'b0, count_reg} > 16'(MAX_SAMPLES)) ? PW'(MAX_SAMPLES) : PW'(count_reg);

    // one RAM per lane, each holding every fourth sample
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [PW-1:0] p;
        assign p = pos_reg + PW'(l);
        assign act[l] = p < limit;
        bgtmv_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES/LANES)) u_ram (
            .aclk(aclk),
            .we(s_fire && s_opcode == OP_WEIGHT && s_weight_index[1:0] == 2'(l)
                && {1'b0, s_weight_index} < 13'(MAX_SAMPLES)),
            .waddr((AW-2)'(s_weight_index >> 2)),
            .wdata(s_weight_value),
            .raddr(p[AW-1:2]),
            .rdata(w[l])
        );
        bgtmv_lane u_lane (
            .aclk(aclk), .code(byte_reg[2*l +: 2]), .active(act[l]),
            .mean_freq(mean_reg), .weight(w[l]), .term_reg(term[l])
        );
    end

    // merge: add all four terms and clamp once (terms sum far below sum range)
    always_comb begin
        localparam logic signed [SUM_WIDTH+2:0] HI = (SUM_WIDTH+3)'({1'b0, {(SUM_WIDTH-1){1'b1}}});
        add = (SUM_WIDTH+3)'(sum_reg) + (SUM_WIDTH+3)'(term[0]) + (SUM_WIDTH+3)'(term[1])
            + (SUM_WIDTH+3)'(term[2]) + (SUM_WIDTH+3)'(term[3]);
        if (add > HI) sum_next = HI[SUM_WIDTH-1:0];
        else if (add < -HI - 1) sum_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
        else sum_next = add[SUM_WIDTH-1:0];
    end

    assign div_start = state_reg == S_DIV && !div_busy;

    bgtmv_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(sum_reg),
        .divisor(scale_reg), .busy(div_busy), .done(div_done), .quotient(div_q),
        .sat(div_sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= 13'd4096;
            pos_reg <= '0;
            sum_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_valid) count_reg <= cfg_data;
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_fire && s_opcode == OP_GENO) begin
                    byte_reg <= s_geno_byte;
                    mean_reg <= s_mean_freq;
                    scale_reg <= s_scale;
                    last_reg <= s_last_byte;
                    state_reg <= S_RD;
                end
                S_RD:  state_reg <= S_MUL;
                S_MUL: state_reg <= S_ACC;
                S_ACC: begin
                    sum_reg <= sum_next;
                    if (pos_reg < limit) pos_reg <= pos_reg + PW'(LANES);
                    state_reg <= last_reg ? S_DIV : S_IDLE;
                end
                S_DIV:  if (div_start) state_reg <= S_WAIT;
                S_WAIT: if (div_done) begin
                    m_projection <= div_q;
                    m_saturated <= div_sat;
                    m_valid <= 1'b1;
                    sum_reg <= '0;
                    pos_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `BGT_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
    `BGT_ASSERT_NXT(a_done_gives_valid, aclk, aresetn, div_done && state_reg == S_WAIT, m_valid)
    `BGT_ASSERT_IMP(a_pos_bounded, aclk, aresetn, 1'b1, pos_reg <= limit + PW'(LANES))
endmodule

>>> src/bgtmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bgtmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> src/bgtmv_lane.sv
// One genotype lane: decodes a 2-bit code and forms (g - 2m) * weight.
// Depends on bgtmv_pkg.
module bgtmv_lane import bgtmv_pkg::*; (
    input  logic                     aclk,
    input  logic [1:0]               code,
    input  logic                     active,
    input  logic [15:0]              mean_freq,
    input  logic signed [15:0]       weight,
    output logic signed [TERM_W-1:0] term_reg
);
    logic signed [18:0] dev;
    logic [17:0] g16;
    always_comb begin
        case (code)
            CODE_HOM2: g16 = 18'h20000;
            CODE_HET:  g16 = 18'h10000;
            default:   g16 = '0;
        endcase
        dev = $signed({1'b0, g16}) - $signed({2'b00, mean_freq, 1'b0});
    end
    always_ff @(posedge aclk) begin
        if (active && code != CODE_MISS) term_reg <= TERM_W'(dev * weight);
        else term_reg <= '0;
    end
endmodule

>>> src/bgtmv_divider.sv
// Restoring divider, one quotient bit per cycle, with 32-bit clamp.
// Depends on bgtmv_pkg.
module bgtmv_divider import bgtmv_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [SUM_WIDTH-1:0] dividend,
    input  logic [15:0]                 divisor,
    output logic                        busy,
    output logic                        done,
    output logic signed [31:0]          quotient,
    output logic                        sat
);
    localparam int CW = $clog2(SUM_WIDTH + 1);
    typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;
    state_t state_reg;
    logic [SUM_WIDTH-1:0] q_reg;
    logic [16:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic neg_reg, zero_reg;
    logic [15:0] d_reg;
    logic [16:0] r_shift;
    logic [17:0] diff;
    logic [SUM_WIDTH:0] qs;
    logic [SUM_WIDTH-1:0] mag;
    logic signed [SUM_WIDTH:0] max_p;
    always_comb begin
        r_shift = {r_reg[15:0], q_reg[SUM_WIDTH-1]};
        diff = {1'b0, r_shift} - {2'b00, d_reg};
        mag = dividend[SUM_WIDTH-1] ? SUM_WIDTH'(-dividend) : dividend;
        qs = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        max_p = (SUM_WIDTH+1)'(32'h7fffffff);
    end
    assign busy = state_reg != IDLE;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                IDLE: if (start) begin
                    q_reg <= mag;
                    r_reg <= '0;
                    d_reg <= divisor;
                    neg_reg <= dividend[SUM_WIDTH-1];
                    zero_reg <= dividend == '0;
                    cnt_reg <= CW'(SUM_WIDTH);
                    state_reg <= RUN;
                end
                RUN: begin
                    if (!diff[17]) begin
                        r_reg <= diff[16:0];
                        q_reg <= {q_reg[SUM_WIDTH-2:0], 1'b1};
                    end else begin
                        r_reg <= r_shift;
                        q_reg <= {q_reg[SUM_WIDTH-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) state_reg <= FIN;
                end
                FIN: begin
                    if (d_reg == '0) begin
                        quotient <= zero_reg ? 32'sd0 : neg_reg ? 32'sh80000000 : 32'sh7fffffff;
                        sat <= !zero_reg;
                    end else if ($signed(qs) > max_p) begin
                        quotient <= 32'sh7fffffff; sat <= 1'b1;
                    end else if ($signed(qs) < -max_p - 1) begin
                        quotient <= 32'sh80000000; sat <= 1'b1;
                    end else begin
                        quotient <= qs[31:0]; sat <= 1'b0;
                    end
                    done <= 1'b1;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
